// ===== rtl/hhels_pkg.sv =====
// shared constants for the http header end and content-length scanner
// character codes, the field name table, the value parse phase codes and the terminator progress codes
// no dependencies
package hhels_pkg;

  // width of the content_length result port
  localparam int unsigned OutLenWidth = 32;

  // length of "content-length:"
  localparam int unsigned NameLen = 15;

  // character codes
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] CaseOfs = 8'h20;

  // value parse phases
  localparam logic [1:0] PhSearch = 2'd0;
  localparam logic [1:0] PhSpaces = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  // terminator progress codes
  localparam logic [1:0] TpNone   = 2'd0;
  localparam logic [1:0] TpCr     = 2'd1;
  localparam logic [1:0] TpCrLf   = 2'd2;
  localparam logic [1:0] TpCrLfCr = 2'd3;

  // lower-case field name, one character per match position
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h6e; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2d; // -
      4'd8:    ch = 8'h6c; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6e; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3a; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/http_header_end_and_length_scanner_core.sv =====
// http header end and content-length scanner, top level
// byte input register, single-pass scan logic and result register
// depends on hhels_pkg
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i / in_ready_o          | byte, last flag in
//   out     | out_valid_o / out_ready_i        | byte and scan flags out
//
// one byte per cycle sustained while the output is ready; a byte's result passes through
// the input register and then the result register before it shows on the output
// the per-byte scan state updates in the same cycle the result register loads
// rst_ni clears all scan state and both valid flags
// a stalled output holds its result and the input register keeps one more byte
module http_header_end_and_length_scanner_core
  import hhels_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             byte_out_o,
  output logic                   is_body_o,
  output logic                   header_end_o,
  output logic                   length_found_o,
  output logic [OutLenWidth-1:0] content_length_o,
  output logic                   header_missing_o
);

  localparam int unsigned ProdWidth = LENGTH_WIDTH + 4;

  // input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register
  logic                    out_v_q;
  logic [7:0]              res_byte_q;
  logic                    res_body_q;
  logic                    res_hend_q;
  logic                    res_found_q;
  logic [LENGTH_WIDTH-1:0] res_len_q;
  logic                    res_missing_q;

  // scan state
  logic [1:0]              term_q, term_d;
  logic                    hdr_done_q, hdr_done_d;
  logic [3:0]              name_idx_q, name_idx_d;
  logic [1:0]              phase_q, phase_d;
  logic [LENGTH_WIDTH-1:0] acc_q, acc_d;

  logic advance;

  // result register frees up when empty or when its transfer happens
  assign advance    = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // scan logic
  logic [7:0]           lc;
  logic [3:0]           idx_cur;
  logic [3:0]           idx_inc;
  logic [ProdWidth-1:0] prod;
  logic                 is_digit;
  logic                 hend;
  logic                 body;
  logic                 found;
  logic                 missing;
  logic [LENGTH_WIDTH-1:0] len;

  always_comb begin
    lc = in_byte_q;
    if (in_byte_q >= ChUpA && in_byte_q <= ChUpZ) begin
      lc = in_byte_q + CaseOfs;
    end
    idx_cur  = (name_idx_q >= 4'(NameLen)) ? 4'd0 : name_idx_q;
    idx_inc  = idx_cur + 4'd1;
    is_digit = (in_byte_q >= ChZero) && (in_byte_q <= ChNine);
    // acc * 10 + digit, the top four bits flag overflow
    prod = {4'b0000, acc_q} * ProdWidth'(10) + ProdWidth'(in_byte_q[3:0]);

    term_d     = term_q;
    hdr_done_d = hdr_done_q;
    name_idx_d = name_idx_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    hend       = 1'b0;
    body       = 1'b0;

    if (hdr_done_q) begin
      body = 1'b1;
    end else begin
      // field name match and value parse
      unique case (phase_q)
        PhSearch: begin
          if (lc == name_char(idx_cur)) begin
            if (idx_inc == 4'(NameLen)) begin
              phase_d    = PhSpaces;
              name_idx_d = 4'd0;
            end else begin
              name_idx_d = idx_inc;
            end
          end else begin
            name_idx_d = (lc == name_char(4'd0)) ? 4'd1 : 4'd0;
          end
        end
        PhSpaces, PhDigits: begin
          if (phase_q == PhSpaces && in_byte_q == ChSpace) begin
            phase_d = phase_q;
          end else if (is_digit) begin
            if (prod[ProdWidth-1:LENGTH_WIDTH] != 4'b0000) begin
              acc_d = '1;
            end else begin
              acc_d = prod[LENGTH_WIDTH-1:0];
            end
            phase_d = PhDigits;
          end else begin
            phase_d = PhDone;
          end
        end
        default: begin
          phase_d = PhDone;
        end
      endcase

      // cr lf cr lf tracking
      priority if (in_byte_q == ChCr) begin
        term_d = (term_q == TpCrLf) ? TpCrLfCr : TpCr;
      end else if (in_byte_q == ChLf) begin
        if (term_q == TpCr) begin
          term_d = TpCrLf;
        end else if (term_q == TpCrLfCr) begin
          term_d     = TpNone;
          hend       = 1'b1;
          hdr_done_d = 1'b1;
        end else begin
          term_d = TpNone;
        end
      end else begin
        term_d = TpNone;
      end
    end

    // result fields
    found   = (phase_d != PhSearch);
    len     = acc_d;
    missing = 1'b0;
    if (in_last_q && !hdr_done_d) begin
      missing = 1'b1;
      found   = 1'b0;
      len     = '0;
    end

    // last byte ends the response
    if (in_last_q) begin
      term_d     = TpNone;
      hdr_done_d = 1'b0;
      name_idx_d = 4'd0;
      phase_d    = PhSearch;
      acc_d      = '0;
    end
  end

  // scan state update, once per byte moved to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q     <= TpNone;
      hdr_done_q <= 1'b0;
      name_idx_q <= 4'd0;
      phase_q    <= PhSearch;
      acc_q      <= '0;
    end else if (advance) begin
      term_q     <= term_d;
      hdr_done_q <= hdr_done_d;
      name_idx_q <= name_idx_d;
      phase_q    <= phase_d;
      acc_q      <= acc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_byte_q    <= in_byte_q;
      res_body_q    <= body;
      res_hend_q    <= hend;
      res_found_q   <= found;
      res_len_q     <= len;
      res_missing_q <= missing;
    end
  end

  // outputs
  assign out_valid_o      = out_v_q;
  assign byte_out_o       = res_byte_q;
  assign is_body_o        = res_body_q;
  assign header_end_o     = res_hend_q;
  assign length_found_o   = res_found_q;
  assign header_missing_o = res_missing_q;

  // fit the length to the 32-bit result port
  if (LENGTH_WIDTH >= OutLenWidth) begin : g_len_trunc
    assign content_length_o = res_len_q[OutLenWidth-1:0];
  end else begin : g_len_ext
    assign content_length_o = {{(OutLenWidth - LENGTH_WIDTH){1'b0}}, res_len_q};
  end

endmodule
